>>> rtl/core/mirc_to_ansi_converter_top_macros.svh
// Assertion macros shared by the mIRC to ANSI converter RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef MIRC_TO_ANSI_CONVERTER_TOP_MACROS_SVH
`define MIRC_TO_ANSI_CONVERTER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define MIRC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define MIRC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define MIRC_ASSERT(lbl, prop)
`define MIRC_ASSERT_NEVER(lbl, cond)
`endif
`endif

>>> rtl/core/mirc_pkg.sv
// Shared types and constants for the mIRC to ANSI converter.
// No dependencies.
package mirc_pkg;

  typedef struct packed {
    logic       func;
    logic [7:0] in_byte;
    logic [6:0] table_index;
    logic [7:0] table_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_PASS,
    ACT_SGR1,
    ACT_SGR2,
    ACT_SGR_NL
  } act_e;

  // table writes reuse fg_code as address and act_byte as data
  typedef struct packed {
    logic       is_wr;
    logic       fg_vld;
    logic [6:0] fg_code;
    logic       bg_vld;
    logic [6:0] bg_code;
    act_e       act;
    logic [7:0] act_byte;
  } cmd_t;

  localparam int unsigned CMDQ_DEPTH = 4;
  localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);

  localparam logic [6:0] NO_COLOUR = 7'd99;

  localparam logic [7:0] CC_BOLD    = 8'h02;
  localparam logic [7:0] CC_COLOUR  = 8'h03;
  localparam logic [7:0] CC_ITALIC  = 8'h09;
  localparam logic [7:0] CC_NL      = 8'h0A;
  localparam logic [7:0] CC_RESET   = 8'h0F;
  localparam logic [7:0] CC_REVERSE = 8'h12;
  localparam logic [7:0] CC_UNDER   = 8'h15;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBR   = 8'h5B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_FOUR  = 8'h34;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_NINE  = 8'h39;

endpackage

>>> rtl/core/mirc_ram.sv
// Generic single write, single read RAM with registered read data.
// No dependencies.
module mirc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 99
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/mirc_cmdq.sv
// Short command queue between front and back of the converter.
// Depends on mirc_pkg.
module mirc_cmdq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mirc_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output mirc_pkg::cmd_t data_o
);

  mirc_pkg::cmd_t                 mem_q [mirc_pkg::CMDQ_DEPTH];
  logic [mirc_pkg::CMDQ_AW-1:0] wptr_q, wptr_d;
  logic [mirc_pkg::CMDQ_AW-1:0] rptr_q, rptr_d;
  logic [mirc_pkg::CMDQ_AW:0]   cnt_q, cnt_d;
  logic                           do_push, do_pop;

  assign full_o  = (cnt_q == (mirc_pkg::CMDQ_AW+1)'(mirc_pkg::CMDQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = do_pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/core/mirc_front.sv
// Front end: classifies input items, tracks flags and colour capture,
// and builds commands for the back end. Depends on mirc_pkg.
module mirc_front #(
  parameter int unsigned TABLE_ENTRIES = 99
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  mirc_pkg::in_item_t item_i,
  output logic               enq_o,
  output mirc_pkg::cmd_t     cmd_o
);

  logic       in_colour_q, in_colour_d;
  logic       bg_phase_q, bg_phase_d;
  logic [1:0] fg_count_q, fg_count_d;
  logic [6:0] fg_value_q, fg_value_d;
  logic [1:0] bg_count_q, bg_count_d;
  logic [6:0] bg_value_q, bg_value_d;
  logic       bold_q, bold_d;
  logic       italic_q, italic_d;
  logic       reverse_q, reverse_d;
  logic       under_q, under_d;

  logic [7:0] b;
  logic       digit;
  logic       consumed;

  assign b     = item_i.in_byte;
  assign digit = b inside {[mirc_pkg::CH_ZERO:mirc_pkg::CH_NINE]};

  always_comb begin
    in_colour_d = in_colour_q;
    bg_phase_d  = bg_phase_q;
    fg_count_d  = fg_count_q;
    fg_value_d  = fg_value_q;
    bg_count_d  = bg_count_q;
    bg_value_d  = bg_value_q;
    bold_d      = bold_q;
    italic_d    = italic_q;
    reverse_d   = reverse_q;
    under_d     = under_q;
    consumed    = 1'b0;
    enq_o       = 1'b0;
    cmd_o       = '0;
    cmd_o.act   = mirc_pkg::ACT_NONE;

    if (accept_i && item_i.func) begin
      cmd_o.is_wr    = 1'b1;
      cmd_o.fg_code  = item_i.table_index;
      cmd_o.act_byte = item_i.table_value;
      enq_o          = (32'(item_i.table_index) < TABLE_ENTRIES);
    end else if (accept_i && (b != mirc_pkg::CH_NUL)) begin
      if (in_colour_q) begin
        if (!bg_phase_q && digit && (fg_count_q < 2'd2)) begin
          fg_value_d = fg_value_q * 7'd10 + {3'b000, b[3:0]};
          fg_count_d = fg_count_q + 2'd1;
          consumed   = 1'b1;
        end else if (!bg_phase_q && (b == mirc_pkg::CH_COMMA)) begin
          bg_phase_d = 1'b1;
          consumed   = 1'b1;
        end else if (bg_phase_q && digit && (bg_count_q < 2'd2)) begin
          bg_value_d = bg_value_q * 7'd10 + {3'b000, b[3:0]};
          bg_count_d = bg_count_q + 2'd1;
          consumed   = 1'b1;
        end else begin
          in_colour_d   = 1'b0;
          bg_phase_d    = 1'b0;
          cmd_o.fg_code = fg_value_q;
          cmd_o.bg_code = bg_value_q;
          cmd_o.fg_vld  = (fg_count_q != 2'd0) && (fg_value_q != mirc_pkg::NO_COLOUR)
                          && (32'(fg_value_q) < TABLE_ENTRIES);
          cmd_o.bg_vld  = (bg_count_q != 2'd0) && (bg_value_q != mirc_pkg::NO_COLOUR)
                          && (32'(bg_value_q) < TABLE_ENTRIES);
        end
      end

      if (!consumed) begin
        case (b)
          mirc_pkg::CC_BOLD: begin
            cmd_o.act      = bold_q ? mirc_pkg::ACT_SGR2 : mirc_pkg::ACT_SGR1;
            cmd_o.act_byte = bold_q ? mirc_pkg::CH_TWO : mirc_pkg::CH_ONE;
            bold_d         = !bold_q;
          end
          mirc_pkg::CC_ITALIC: begin
            cmd_o.act      = italic_q ? mirc_pkg::ACT_SGR2 : mirc_pkg::ACT_SGR1;
            cmd_o.act_byte = mirc_pkg::CH_THREE;
            italic_d       = !italic_q;
          end
          mirc_pkg::CC_REVERSE: begin
            cmd_o.act      = reverse_q ? mirc_pkg::ACT_SGR2 : mirc_pkg::ACT_SGR1;
            cmd_o.act_byte = mirc_pkg::CH_SEVEN;
            reverse_d      = !reverse_q;
          end
          mirc_pkg::CC_UNDER: begin
            cmd_o.act      = under_q ? mirc_pkg::ACT_SGR2 : mirc_pkg::ACT_SGR1;
            cmd_o.act_byte = mirc_pkg::CH_FOUR;
            under_d        = !under_q;
          end
          mirc_pkg::CC_COLOUR: begin
            in_colour_d = 1'b1;
            bg_phase_d  = 1'b0;
            fg_count_d  = 2'd0;
            fg_value_d  = 7'd0;
            bg_count_d  = 2'd0;
            bg_value_d  = 7'd0;
          end
          mirc_pkg::CC_RESET, mirc_pkg::CC_NL: begin
            cmd_o.act      = (b == mirc_pkg::CC_NL) ? mirc_pkg::ACT_SGR_NL
                                                    : mirc_pkg::ACT_SGR1;
            cmd_o.act_byte = mirc_pkg::CH_ZERO;
            bold_d         = 1'b0;
            italic_d       = 1'b0;
            reverse_d      = 1'b0;
            under_d        = 1'b0;
          end
          default: begin
            cmd_o.act      = mirc_pkg::ACT_PASS;
            cmd_o.act_byte = b;
          end
        endcase
        enq_o = cmd_o.fg_vld || cmd_o.bg_vld || (cmd_o.act != mirc_pkg::ACT_NONE);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_colour_q <= 1'b0;
      bg_phase_q  <= 1'b0;
      fg_count_q  <= 2'd0;
      fg_value_q  <= 7'd0;
      bg_count_q  <= 2'd0;
      bg_value_q  <= 7'd0;
      bold_q      <= 1'b0;
      italic_q    <= 1'b0;
      reverse_q   <= 1'b0;
      under_q     <= 1'b0;
    end else begin
      in_colour_q <= in_colour_d;
      bg_phase_q  <= bg_phase_d;
      fg_count_q  <= fg_count_d;
      fg_value_q  <= fg_value_d;
      bg_count_q  <= bg_count_d;
      bg_value_q  <= bg_value_d;
      bold_q      <= bold_d;
      italic_q    <= italic_d;
      reverse_q   <= reverse_d;
      under_q     <= under_d;
    end
  end

endmodule

>>> rtl/core/mirc_back.sv
// Back end: serializes commands into output bytes, owns the colour table.
// Depends on mirc_pkg, mirc_ram and the assertion macro header.
`include "mirc_to_ansi_converter_top_macros.svh"
module mirc_back #(
  parameter int unsigned TABLE_ENTRIES = 99
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  mirc_pkg::cmd_t      q_data_i,
  output logic                q_pop_o,
  input  logic                pop,
  output logic                empty,
  output mirc_pkg::out_item_t out_data_o
);

  localparam int unsigned TAW = $clog2(TABLE_ENTRIES);

  localparam logic [1:0] PH_FG  = 2'd0;
  localparam logic [1:0] PH_BG  = 2'd1;
  localparam logic [1:0] PH_ACT = 2'd2;

  mirc_pkg::cmd_t      cur_q, cur_d;
  logic                cur_vld_q, cur_vld_d;
  logic [1:0]          phase_q, phase_d;
  logic [3:0]          pos_q, pos_d;
  logic                out_vld_q, out_vld_d;
  mirc_pkg::out_item_t out_q, out_d;

  logic           ram_we, ram_re;
  logic [TAW-1:0] ram_raddr;
  logic [7:0]     ram_rdata;

  logic [1:0]  hund;
  logic [7:0]  rem8;
  logic [14:0] prod;
  logic [3:0]  tens;
  logic [6:0]  ones7;
  logic [1:0]  ndig;
  logic [3:0]  dsel;
  logic [7:0]  dchar;
  logic [7:0]  byte_c;
  logic        phase_end;
  logic        cmd_done;
  logic        emit;
  logic        load_slot;

  mirc_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (q_data_i.fg_code[TAW-1:0]),
    .wdata_i (q_data_i.act_byte),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // decimal digits of the palette index
  always_comb begin
    if (ram_rdata >= 8'd200) begin
      hund = 2'd2;
      rem8 = ram_rdata - 8'd200;
    end else if (ram_rdata >= 8'd100) begin
      hund = 2'd1;
      rem8 = ram_rdata - 8'd100;
    end else begin
      hund = 2'd0;
      rem8 = ram_rdata;
    end
    prod  = {8'b0, rem8[6:0]} * 15'd205;
    tens  = prod[14:11];
    ones7 = rem8[6:0] - {3'b000, tens} * 7'd10;
    if (ram_rdata >= 8'd100) begin
      ndig = 2'd3;
    end else if (ram_rdata >= 8'd10) begin
      ndig = 2'd2;
    end else begin
      ndig = 2'd1;
    end
    dsel = pos_q - 4'd7 + (4'd3 - {2'b00, ndig});
    case (dsel)
      4'd0:    dchar = mirc_pkg::CH_ZERO | {6'b0, hund};
      4'd1:    dchar = mirc_pkg::CH_ZERO | {4'b0, tens};
      default: dchar = mirc_pkg::CH_ZERO | {4'b0, ones7[3:0]};
    endcase
  end

  always_comb begin
    byte_c    = mirc_pkg::CH_ESC;
    phase_end = 1'b0;
    if (phase_q == PH_ACT) begin
      case (cur_q.act)
        mirc_pkg::ACT_PASS: begin
          byte_c    = cur_q.act_byte;
          phase_end = 1'b1;
        end
        mirc_pkg::ACT_SGR1, mirc_pkg::ACT_SGR_NL: begin
          case (pos_q)
            4'd0:    byte_c = mirc_pkg::CH_ESC;
            4'd1:    byte_c = mirc_pkg::CH_LBR;
            4'd2:    byte_c = cur_q.act_byte;
            4'd3:    byte_c = mirc_pkg::CH_M;
            default: byte_c = mirc_pkg::CC_NL;
          endcase
          phase_end = (cur_q.act == mirc_pkg::ACT_SGR1) ? (pos_q == 4'd3) : (pos_q == 4'd4);
        end
        mirc_pkg::ACT_SGR2: begin
          case (pos_q)
            4'd0:    byte_c = mirc_pkg::CH_ESC;
            4'd1:    byte_c = mirc_pkg::CH_LBR;
            4'd2:    byte_c = mirc_pkg::CH_TWO;
            4'd3:    byte_c = cur_q.act_byte;
            default: byte_c = mirc_pkg::CH_M;
          endcase
          phase_end = (pos_q == 4'd4);
        end
        default: begin
          byte_c    = mirc_pkg::CH_ESC;
          phase_end = 1'b1;
        end
      endcase
    end else begin
      phase_end = (pos_q == 4'd7 + {2'b00, ndig});
      case (pos_q)
        4'd0:    byte_c = mirc_pkg::CH_ESC;
        4'd1:    byte_c = mirc_pkg::CH_LBR;
        4'd2:    byte_c = (phase_q == PH_BG) ? mirc_pkg::CH_FOUR : mirc_pkg::CH_THREE;
        4'd3:    byte_c = mirc_pkg::CH_EIGHT;
        4'd4:    byte_c = mirc_pkg::CH_SEMI;
        4'd5:    byte_c = mirc_pkg::CH_FIVE;
        4'd6:    byte_c = mirc_pkg::CH_SEMI;
        default: byte_c = phase_end ? mirc_pkg::CH_M : dchar;
      endcase
    end
    cmd_done = phase_end && ((phase_q == PH_ACT)
               || ((phase_q == PH_BG) && (cur_q.act == mirc_pkg::ACT_NONE))
               || ((phase_q == PH_FG) && !cur_q.bg_vld
                   && (cur_q.act == mirc_pkg::ACT_NONE)));
  end

  assign emit      = cur_vld_q && (!out_vld_q || pop);
  assign load_slot = !cur_vld_q || (emit && cmd_done);

  always_comb begin
    cur_d     = cur_q;
    cur_vld_d = cur_vld_q;
    phase_d   = phase_q;
    pos_d     = pos_q;
    out_vld_d = out_vld_q && !pop;
    out_d     = out_q;
    q_pop_o   = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = cur_q.bg_code[TAW-1:0];

    if (emit) begin
      out_vld_d      = 1'b1;
      out_d.out_byte = byte_c;
      out_d.last     = cmd_done;
      if (phase_end) begin
        pos_d = 4'd0;
        if ((phase_q == PH_FG) && cur_q.bg_vld) begin
          phase_d = PH_BG;
          ram_re  = 1'b1;
        end else begin
          phase_d = PH_ACT;
        end
      end else begin
        pos_d = pos_q + 4'd1;
      end
    end

    if (load_slot) begin
      cur_vld_d = 1'b0;
      if (!q_empty_i) begin
        q_pop_o = 1'b1;
        if (q_data_i.is_wr) begin
          ram_we = 1'b1;
        end else begin
          cur_vld_d = 1'b1;
          cur_d     = q_data_i;
          pos_d     = 4'd0;
          ram_re    = q_data_i.fg_vld || q_data_i.bg_vld;
          ram_raddr = q_data_i.fg_vld ? q_data_i.fg_code[TAW-1:0]
                                      : q_data_i.bg_code[TAW-1:0];
          if (q_data_i.fg_vld) begin
            phase_d = PH_FG;
          end else if (q_data_i.bg_vld) begin
            phase_d = PH_BG;
          end else begin
            phase_d = PH_ACT;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      phase_q   <= PH_ACT;
      pos_q     <= 4'd0;
      out_vld_q <= 1'b0;
    end else begin
      cur_vld_q <= cur_vld_d;
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  assign empty      = !out_vld_q;
  assign out_data_o = out_q;

  `MIRC_ASSERT(a_fg_phase_has_fg, (cur_vld_q && (phase_q == PH_FG)) |-> cur_q.fg_vld)
  `MIRC_ASSERT(a_bg_phase_has_bg, (cur_vld_q && (phase_q == PH_BG)) |-> cur_q.bg_vld)
  `MIRC_ASSERT_NEVER(a_ram_rw_clash, ram_we && ram_re)
  `MIRC_ASSERT(a_pos_bound, (cur_vld_q && (phase_q == PH_ACT)) |-> (pos_q < 4'd5))
  `MIRC_ASSERT(a_cur_no_write, cur_vld_q |-> !cur_q.is_wr)

endmodule

>>> rtl/core/mirc_to_ansi_converter_top.sv
// Top level of the mIRC formatting to ANSI escape converter.
// Depends on mirc_pkg, mirc_front, mirc_cmdq and mirc_back.
//
// Usage:
//   Input queue: drive in_data_i and raise push; the item is taken at an edge
//   where push is high and full is low. func 1 writes one colour table entry,
//   func 0 converts one text byte. Entries must be written before use.
//   Output queue: while empty is low, out_data_o holds the oldest output byte;
//   it is taken at an edge where pop is high. last marks the final byte of the
//   bytes produced by one input item.
//   Flow: an item is classified in the cycle it is taken; its command goes
//   via the command queue to the serializer, which registers each output
//   byte. Plain text runs at one byte per cycle while pop is held high. Each
//   escape sequence is sent one byte per cycle likewise, up to 27 bytes for
//   one item; the four-entry command queue between the classifier and the
//   serializer absorbs short bursts and then holds full high. Table writes
//   pass through the same queue and give no output byte. A stalled receiver
//   holds the output byte; the serializer and then the queue back up, and
//   input stalls only once the queue is full. Reset clears flags, colour
//   capture, queue and output; table contents are left as they are.
module mirc_to_ansi_converter_top #(
  parameter int unsigned TABLE_ENTRIES = 99
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  mirc_pkg::in_item_t  in_data_i,
  output logic                empty,
  input  logic                pop,
  output mirc_pkg::out_item_t out_data_o
);

  logic           accept;
  logic           enq;
  mirc_pkg::cmd_t enq_cmd;
  logic           q_empty;
  logic           q_pop;
  mirc_pkg::cmd_t q_head;

  assign accept = push && !full;

  mirc_front #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .enq_o    (enq),
    .cmd_o    (enq_cmd)
  );

  mirc_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && enq),
    .data_i  (enq_cmd),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_head)
  );

  mirc_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_data_i   (q_head),
    .q_pop_o    (q_pop),
    .pop        (pop),
    .empty      (empty),
    .out_data_o (out_data_o)
  );

endmodule
